// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
// no dependencies; clocked checks assume signals named clock and reset in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define CHK_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// condition must never be seen out of reset
`define CHK_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define CHK_ASSERT(label, prop, msg)
`define CHK_NEVER(label, cond, msg)
`endif
`endif

// ===== rtl/ppre_pkg.sv =====
// types and constants of the packed pixel run length encoder
// no dependencies
package ppre_pkg;

   localparam int WORD_BITS       = 32;
   localparam int COUNT_BYTE_MAX  = 255;
   localparam int PAD_PIXELS      = 16;

   // largest final count byte before a 255 byte is spent
   localparam logic [7:0] TAIL_MAX     = 8'(COUNT_BYTE_MAX - 1);
   localparam logic [5:0] WORD_PIXELS  = 6'(WORD_BITS);

   typedef enum logic [1:0] {
      DEPTH_1BIT = 2'd0,
      DEPTH_2BIT = 2'd1,
      DEPTH_4BIT = 2'd2,
      DEPTH_8BIT = 2'd3
   } depth_mode_type;

endpackage

// ===== rtl/packed_pixel_run_length_encoder_top.sv =====
// packed pixel run length encoder, top level
// depends on ppre_pkg and assert_macros.svh
//
//   channel | direction | handshake           | contents
//   req_    | in        | valid / stall       | one 32-bit word of packed pixels, last, pad flag
//   rsp_    | out       | valid / stall       | one finished run (value, 255 bytes, tail byte)
//   csr_    | in        | valid / ready       | depth_mode
//
// a word is taken in the idle state, then its pixels are shifted out of a word
// register one pixel per cycle: 32, 16, 8 or 4 pixels at 1, 2, 4 or 8 bits per pixel,
// and the last word of a tile is followed by a flush state that emits the open run.
// a pixel that closes a run waits while the output register is full and stalled.
// reset is synchronous: depth 8 bits, open run cleared, first word of a tile pending.
// the run length is kept directly as 255 bytes and a tail byte, so no divider is needed.
`include "assert_macros.svh"

module packed_pixel_run_length_encoder_top
   import ppre_pkg::*;
#(
   parameter int TILE_PIXELS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_pixel_word,
   input  logic        req_last_word,
   input  logic        req_pad_low_half,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_run_valid,
   output logic [7:0]  rsp_run_value,
   output logic [4:0]  rsp_full_count_bytes,
   output logic [7:0]  rsp_tail_count,
   output logic        rsp_last_run,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_depth_mode
);

   // run length minus one never exceeds TILE_PIXELS - 1
   localparam int              LEN_W   = $clog2(TILE_PIXELS);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(TILE_PIXELS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PIXELS,
      ST_FLUSH
   } state_type;

   state_type            state_ff, state_in;
   depth_mode_type       depth_ff, depth_in;          // configured depth
   depth_mode_type       word_depth_ff, word_depth_in; // depth of the word in work
   logic [WORD_BITS-1:0] word_ff, word_in;            // pixel shift register
   logic [5:0]           pix_left_ff, pix_left_in;
   logic                 last_ff, last_in;
   logic                 pad_ff, pad_in;

   // open run: value, length minus one, and the same split into 255 bytes and tail
   logic                 tile_start_ff, tile_start_in;
   logic [7:0]           run_pixel_ff, run_pixel_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [4:0]           full_ff, full_in;
   logic [7:0]           tail_ff, tail_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_run_valid_ff, rsp_run_valid_in;
   logic [7:0]           rsp_run_value_ff, rsp_run_value_in;
   logic [4:0]           rsp_full_ff, rsp_full_in;
   logic [7:0]           rsp_tail_ff, rsp_tail_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 out_free;
   logic [7:0]           pixel;
   logic [WORD_BITS-1:0] word_shifted;
   logic                 pad_active;
   logic                 len_ge_pad;
   logic                 step_ok;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign pad_active = (word_depth_ff == DEPTH_1BIT) && pad_ff;
   assign len_ge_pad = (32'(len_ff) >= 32'(PAD_PIXELS));

   // leftmost pixel of the word register and the register after it is consumed
   always_comb begin
      unique case (word_depth_ff)
         DEPTH_1BIT: begin
            pixel        = {7'd0, word_ff[WORD_BITS-1]};
            word_shifted = word_ff << 1;
         end
         DEPTH_2BIT: begin
            pixel        = {6'd0, word_ff[WORD_BITS-1 -: 2]};
            word_shifted = word_ff << 2;
         end
         DEPTH_4BIT: begin
            pixel        = {4'd0, word_ff[WORD_BITS-1 -: 4]};
            word_shifted = word_ff << 4;
         end
         default: begin
            pixel        = word_ff[WORD_BITS-1 -: 8];
            word_shifted = word_ff << 8;
         end
      endcase
   end

   // a pixel can always be taken unless it closes a run and the output is blocked
   assign step_ok = tile_start_ff || (pixel == run_pixel_ff) || out_free;

   always_comb begin
      state_in         = state_ff;
      depth_in         = depth_ff;
      word_depth_in    = word_depth_ff;
      word_in          = word_ff;
      pix_left_in      = pix_left_ff;
      last_in          = last_ff;
      pad_in           = pad_ff;
      tile_start_in    = tile_start_ff;
      run_pixel_in     = run_pixel_ff;
      len_in           = len_ff;
      full_in          = full_ff;
      tail_in          = tail_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_run_valid_in = rsp_run_valid_ff;
      rsp_run_value_in = rsp_run_value_ff;
      rsp_full_in      = rsp_full_ff;
      rsp_tail_in      = rsp_tail_ff;
      rsp_last_in      = rsp_last_ff;

      if (csr_valid) begin
         depth_in = depth_mode_type'(csr_depth_mode);
      end

      // result taken downstream
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               word_in       = req_pixel_word;
               last_in       = req_last_word;
               pad_in        = req_pad_low_half;
               word_depth_in = depth_ff;
               pix_left_in   = WORD_PIXELS >> depth_ff;
               state_in      = ST_PIXELS;
            end
         end

         ST_PIXELS: begin
            if (step_ok) begin
               word_in     = word_shifted;
               pix_left_in = pix_left_ff - 6'd1;
               priority if (tile_start_ff) begin
                  // first pixel of the tile opens a run of one
                  tile_start_in = 1'b0;
                  run_pixel_in  = pixel;
                  len_in        = '0;
                  full_in       = 5'd0;
                  tail_in       = 8'd0;
               end else if (pixel == run_pixel_ff) begin
                  // extend the run, saturating at the tile size
                  if (len_ff != LEN_MAX) begin
                     len_in = len_ff + LEN_W'(1);
                     if (tail_ff == TAIL_MAX) begin
                        tail_in = 8'd0;
                        full_in = full_ff + 5'd1;
                     end else begin
                        tail_in = tail_ff + 8'd1;
                     end
                  end
               end else begin
                  // run closed: emit it and open a new one
                  rsp_valid_in     = 1'b1;
                  rsp_run_valid_in = 1'b1;
                  rsp_run_value_in = run_pixel_ff;
                  rsp_full_in      = full_ff;
                  rsp_tail_in      = tail_ff;
                  rsp_last_in      = 1'b0;
                  run_pixel_in     = pixel;
                  len_in           = '0;
                  full_in          = 5'd0;
                  tail_in          = 8'd0;
               end
               if (pix_left_ff == 6'd1) begin
                  state_in = last_ff ? ST_FLUSH : ST_IDLE;
               end
            end
         end

         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               priority if (pad_active && !len_ge_pad) begin
                  // run made only of padding: end marker
                  rsp_run_valid_in = 1'b0;
                  rsp_run_value_in = 8'd0;
                  rsp_full_in      = 5'd0;
                  rsp_tail_in      = 8'd0;
               end else if (pad_active) begin
                  // strip the padded half from the split count
                  rsp_run_valid_in = 1'b1;
                  rsp_run_value_in = run_pixel_ff;
                  if (tail_ff >= 8'(PAD_PIXELS)) begin
                     rsp_full_in = full_ff;
                     rsp_tail_in = tail_ff - 8'(PAD_PIXELS);
                  end else begin
                     rsp_full_in = full_ff - 5'd1;
                     rsp_tail_in = tail_ff + 8'(COUNT_BYTE_MAX - PAD_PIXELS);
                  end
               end else begin
                  rsp_run_valid_in = 1'b1;
                  rsp_run_value_in = run_pixel_ff;
                  rsp_full_in      = full_ff;
                  rsp_tail_in      = tail_ff;
               end
               // re-arm for the next tile
               tile_start_in = 1'b1;
               run_pixel_in  = 8'd0;
               len_in        = '0;
               full_in       = 5'd0;
               tail_in       = 8'd0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         depth_ff      <= DEPTH_8BIT;
         pix_left_ff   <= 6'd0;
         tile_start_ff <= 1'b1;
         run_pixel_ff  <= 8'd0;
         len_ff        <= '0;
         full_ff       <= 5'd0;
         tail_ff       <= 8'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         depth_ff      <= depth_in;
         pix_left_ff   <= pix_left_in;
         tile_start_ff <= tile_start_in;
         run_pixel_ff  <= run_pixel_in;
         len_ff        <= len_in;
         full_ff       <= full_in;
         tail_ff       <= tail_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      // payload, no reset needed
      word_ff          <= word_in;
      word_depth_ff    <= word_depth_in;
      last_ff          <= last_in;
      pad_ff           <= pad_in;
      rsp_run_valid_ff <= rsp_run_valid_in;
      rsp_run_value_ff <= rsp_run_value_in;
      rsp_full_ff      <= rsp_full_in;
      rsp_tail_ff      <= rsp_tail_in;
      rsp_last_ff      <= rsp_last_in;
   end

   // a new word is taken only between words
   assign req_stall            = (state_ff != ST_IDLE);
   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_run_valid        = rsp_run_valid_ff;
   assign rsp_run_value        = rsp_run_value_ff;
   assign rsp_full_count_bytes = rsp_full_ff;
   assign rsp_tail_count       = rsp_tail_ff;
   assign rsp_last_run         = rsp_last_ff;

   // checks
   `CHK_ASSERT(a_start_clear, tile_start_ff |-> (len_ff == '0 && full_ff == 5'd0 && tail_ff == 8'd0), "open run not cleared while tile start pending")
   `CHK_NEVER(a_pixels_left, state_ff == ST_PIXELS && pix_left_ff == 6'd0, "pixel loop with no pixels left")
   `CHK_ASSERT(a_flush_rearm, (state_ff == ST_FLUSH && out_free) |=> (tile_start_ff && rsp_valid_ff && rsp_last_ff), "flush did not emit last run and re-arm")

endmodule
